// ===== rtl/core/lrusc_pkg.sv =====
// lrusc_pkg: shared constants, payload types and controller/datapath command types
// for the lru write-back sector cache; no dependencies
package lrusc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int TAG_W   = 32;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              writeback_valid;
    logic [TAG_W-1:0]  writeback_sector;
    logic              fill_needed;
    logic              last;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch request, run tag and lru compares
    logic resolve;   // pick hit slot or victim, start tag read
    logic commit;    // write result of a request, update slot state
    logic fl_clear;  // rank counter to lru end
    logic fl_find;   // locate slot holding current rank
    logic fl_read;   // select that slot, start tag read
    logic fl_emit;   // report write-back, clean slot, next rank
    logic fl_skip;   // slot clean, next rank
    logic fl_empty;  // flush found nothing dirty
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic any_dirty;
    logic sel_wb;
    logic fl_last;
  } sts_t;

  function automatic logic [IDX_W-1:0] onehot_enc(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (v[i]) begin
        r = r | IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lrusc_if.sv =====
// lrusc_req_if and lrusc_rsp_if: valid/ready channels for requests and results
// depends on lrusc_pkg
interface lrusc_req_if;
  import lrusc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [TAG_W-1:0] sector;
  modport source (output valid, output cmd, output sector, input ready);
  modport sink (input valid, input cmd, input sector, output ready);
endinterface

interface lrusc_rsp_if;
  import lrusc_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              writeback_valid;
  logic [TAG_W-1:0]  writeback_sector;
  logic              fill_needed;
  logic              last;
  modport source (output valid, output hit, output slot, output writeback_valid,
                  output writeback_sector, output fill_needed, output last,
                  input ready);
  modport sink (input valid, input hit, input slot, input writeback_valid,
                input writeback_sector, input fill_needed, input last,
                output ready);
endinterface

// ===== rtl/core/lrusc_dp.sv =====
// lrusc_dp: slot state (valid, dirty, tags, lru ranks), tag memory and result register
// depends on lrusc_pkg
module lrusc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  lrusc_pkg::ctl_t               ctl,
  output lrusc_pkg::sts_t               sts,
  input  logic [lrusc_pkg::CMD_W-1:0]   cmd,
  input  logic [lrusc_pkg::TAG_W-1:0]   sector,
  output lrusc_pkg::rsp_t               rsp_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready
);
  import lrusc_pkg::*;

  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] dirty;
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] pick_vec;
  logic [ENTRIES-1:0] cmp_vec;
  logic [ENTRIES-1:0] zero_vec;
  logic [ENTRIES-1:0] cnt_vec;
  logic [ENTRIES-1:0] vd;
  logic [TAG_W-1:0]   tag_q [ENTRIES];
  logic [TAG_W-1:0]   tag_mem [ENTRIES];
  logic [TAG_W-1:0]   rd_tag;
  logic [TAG_W-1:0]   sector_q;
  logic [IDX_W-1:0]   rank [ENTRIES];
  logic [IDX_W-1:0]   sel_q;
  logic [IDX_W-1:0]   sel_next;
  logic [IDX_W-1:0]   sel_rank;
  logic [IDX_W-1:0]   cnt;
  logic               write_q;
  logic               hit_q;
  logic               sel_wb_q;
  logic               fl_last;
  logic               load;
  rsp_t               rsp_next;

  // per-slot comparators
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cmp_vec[i]  = valid[i] && (tag_q[i] == sector);
      zero_vec[i] = (rank[i] == '0);
      cnt_vec[i]  = (rank[i] == cnt);
    end
  end

  assign sel_next = (ctl.resolve && (|match_vec)) ? onehot_enc(match_vec)
                                                  : onehot_enc(pick_vec);
  assign sel_rank = rank[sel_q];
  assign vd       = valid & dirty;
  assign fl_last  = ((vd & ~pick_vec) == '0);
  assign load     = ctl.commit || ctl.fl_emit || ctl.fl_empty;

  always_comb begin
    rsp_next = '0;
    if (ctl.commit) begin
      rsp_next.hit              = hit_q;
      rsp_next.slot             = SLOT_W'(sel_q);
      rsp_next.writeback_valid  = sel_wb_q && !hit_q;
      rsp_next.writeback_sector = (sel_wb_q && !hit_q) ? rd_tag : '0;
      rsp_next.fill_needed      = !hit_q && !write_q;
      rsp_next.last             = 1'b1;
    end else if (ctl.fl_emit) begin
      rsp_next.slot             = SLOT_W'(sel_q);
      rsp_next.writeback_valid  = 1'b1;
      rsp_next.writeback_sector = rd_tag;
      rsp_next.last             = fl_last;
    end else if (ctl.fl_empty) begin
      rsp_next.last = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      dirty     <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= IDX_W'(i);
      end
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (ctl.commit) begin
        if (hit_q) begin
          dirty[sel_q] <= dirty[sel_q] || write_q;
        end else begin
          valid[sel_q] <= 1'b1;
          dirty[sel_q] <= write_q;
        end
        // make selected slot mru
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == sel_q) begin
            rank[i] <= IDX_W'(ENTRIES - 1);
          end else if (rank[i] > sel_rank) begin
            rank[i] <= rank[i] - 1'b1;
          end
        end
      end
      if (ctl.fl_emit) begin
        dirty[sel_q] <= 1'b0;
      end
      if (ctl.fl_clear) begin
        cnt <= '0;
      end else if (ctl.fl_emit || ctl.fl_skip) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      sector_q  <= sector;
      write_q   <= (cmd == CMD_WRITE);
      match_vec <= cmp_vec;
      pick_vec  <= zero_vec;
    end
    if (ctl.fl_find) begin
      pick_vec <= cnt_vec;
    end
    if (ctl.resolve || ctl.fl_read) begin
      sel_q    <= sel_next;
      hit_q    <= ctl.resolve && (|match_vec);
      sel_wb_q <= vd[sel_next];
    end
    if (ctl.commit && !hit_q) begin
      tag_q[sel_q] <= sector_q;
    end
    if (load) begin
      rsp_data <= rsp_next;
    end
  end

  // tag memory, indexed copy of the tags
  always_ff @(posedge clk) begin
    if (ctl.commit && !hit_q) begin
      tag_mem[sel_q] <= sector_q;
    end
    if (ctl.resolve || ctl.fl_read) begin
      rd_tag <= tag_mem[sel_next];
    end
  end

  assign sts.out_free  = !rsp_valid || rsp_ready;
  assign sts.any_dirty = |vd;
  assign sts.sel_wb    = sel_wb_q;
  assign sts.fl_last   = fl_last;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> sts.out_free)
    else $error("result loaded while register still occupied");
  a_commit_mru: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> rank[$past(sel_q)] == IDX_W'(ENTRIES - 1))
    else $error("committed slot not mru");
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> valid[$past(sel_q)])
    else $error("committed slot not valid");
  a_find_onehot: assert property (@(posedge clk) disable iff (rst)
    ctl.fl_find |=> $onehot(pick_vec))
    else $error("rank not held by exactly one slot");
  a_emit_dirty: assert property (@(posedge clk) disable iff (rst)
    ctl.fl_emit |-> (sel_wb_q && vd[sel_q]))
    else $error("flush write-back of a clean slot");

endmodule

// ===== rtl/core/lrusc_ctrl.sv =====
// lrusc_ctrl: sequencing state machine for requests and flush walks
// depends on lrusc_pkg
module lrusc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [lrusc_pkg::CMD_W-1:0] req_cmd,
  output logic                        req_ready,
  output lrusc_pkg::ctl_t             ctl,
  input  lrusc_pkg::sts_t             sts
);
  import lrusc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RESOLVE = 3'd1;
  localparam logic [2:0] S_COMMIT  = 3'd2;
  localparam logic [2:0] S_FFIND   = 3'd3;
  localparam logic [2:0] S_FREAD   = 3'd4;
  localparam logic [2:0] S_FEMIT   = 3'd5;
  localparam logic [2:0] S_FEMPTY  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_cmd == CMD_READ || req_cmd == CMD_WRITE) begin
            ctl.capture = 1'b1;
            state_next  = S_RESOLVE;
          end else if (req_cmd == CMD_FLUSH) begin
            ctl.fl_clear = 1'b1;
            state_next   = sts.any_dirty ? S_FFIND : S_FEMPTY;
          end
        end
      end
      S_RESOLVE: begin
        ctl.resolve = 1'b1;
        state_next  = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FFIND: begin
        ctl.fl_find = 1'b1;
        state_next  = S_FREAD;
      end
      S_FREAD: begin
        ctl.fl_read = 1'b1;
        state_next  = S_FEMIT;
      end
      S_FEMIT: begin
        if (!sts.sel_wb) begin
          ctl.fl_skip = 1'b1;
          state_next  = S_FFIND;
        end else if (sts.out_free) begin
          ctl.fl_emit = 1'b1;
          state_next  = sts.fl_last ? S_IDLE : S_FFIND;
        end
      end
      S_FEMPTY: begin
        if (sts.out_free) begin
          ctl.fl_empty = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl))
    else $error("more than one datapath command");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> req_ready)
    else $error("not idle after request commit");
  a_resolve_after_capture: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> ctl.resolve)
    else $error("capture not followed by resolve");

endmodule

// ===== rtl/core/lru_write_back_sector_cache_top.sv =====
// lru_write_back_sector_cache_top: tag and lru replacement controller for a
// fully associative write-back sector cache; depends on lrusc_pkg, lrusc_if,
// lrusc_ctrl and lrusc_dp
//
//   channel  dir  fields
//   -------  ---  -------------------------------------------------------------
//   req      in   cmd, sector
//   rsp      out  hit, slot, writeback_valid, writeback_sector, fill_needed, last
//
// a read or write runs these steps, its commit waiting for a free result register:
//   accept (parallel tag compare, lru search), resolve (slot select, tag read),
//   commit (result out, valid/dirty/tag/rank update)
// a flush walks ranks lru to mru after the accepting cycle, each by rank search,
//   slot select and tag read, then emit (once the result register is free) or skip;
//   it ends at the last dirty slot, or with one result marked last if none is dirty
// reset clears valid and dirty bits and sets rank to slot index; no clearing pass
// a result waits in the output register while rsp stalls; the next request is
//   already taken meanwhile and only its commit waits for the register to drain
module lru_write_back_sector_cache_top (
  input logic        clk,
  input logic        rst,
  lrusc_req_if.sink   req,
  lrusc_rsp_if.source rsp
);
  import lrusc_pkg::*;

  ctl_t ctl;      // controller commands
  sts_t sts;      // datapath status
  rsp_t rsp_data; // registered result payload
  logic rsp_valid;

  // sequencing
  lrusc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  // slot state, tag memory and result register
  lrusc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd       (req.cmd),
    .sector    (req.sector),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready)
  );

  // result channel straight from the output register
  assign rsp.valid            = rsp_valid;
  assign rsp.hit              = rsp_data.hit;
  assign rsp.slot             = rsp_data.slot;
  assign rsp.writeback_valid  = rsp_data.writeback_valid;
  assign rsp.writeback_sector = rsp_data.writeback_sector;
  assign rsp.fill_needed      = rsp_data.fill_needed;
  assign rsp.last             = rsp_data.last;

endmodule
